>>> hdl/lkdhid_pkg.sv
// Shared types, constants and decode functions for the ladder keypad block.
// No dependencies; every other file in hdl/ imports this package.
package lkdhid_pkg;

  // Field widths
  localparam int unsigned LADDER_W = 12;
  localparam int unsigned USAGE_W  = 8;
  localparam int unsigned KEY_W    = 4;
  localparam int unsigned STABLE_W = 11;
  localparam int unsigned UNLOCK_W = 12;
  localparam int unsigned DEB_W    = 10;
  localparam int unsigned KEEP_W   = 20;
  localparam int unsigned WAIT_W   = 12;
  localparam int unsigned GAP_W    = 12;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 4;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_NONE    = 4'd0;
  localparam logic [KEY_W-1:0] KEY_NEXT    = 4'd1;
  localparam logic [KEY_W-1:0] KEY_PREV    = 4'd2;
  localparam logic [KEY_W-1:0] KEY_PLUS    = 4'd3;
  localparam logic [KEY_W-1:0] KEY_MINUS   = 4'd4;
  localparam logic [KEY_W-1:0] KEY_MUTE    = 4'd5;
  localparam logic [KEY_W-1:0] KEY_SOURCE  = 4'd6;
  localparam logic [KEY_W-1:0] KEY_ANSWER  = 4'd7;
  localparam logic [KEY_W-1:0] KEY_HANGUP  = 4'd8;
  localparam logic [KEY_W-1:0] KEY_VOICE   = 4'd9;
  localparam logic [KEY_W-1:0] KEY_UNKNOWN = 4'd15;

  // Consumer usage bytes
  localparam logic [USAGE_W-1:0] USAGE_RELEASE = 8'h00;
  localparam logic [USAGE_W-1:0] USAGE_MENU    = 8'h01;
  localparam logic [USAGE_W-1:0] USAGE_HELP    = 8'h02;
  localparam logic [USAGE_W-1:0] USAGE_NEXT    = 8'h04;
  localparam logic [USAGE_W-1:0] USAGE_PREV    = 8'h08;
  localparam logic [USAGE_W-1:0] USAGE_PLAY    = 8'h10;
  localparam logic [USAGE_W-1:0] USAGE_VOLUP   = 8'h40;
  localparam logic [USAGE_W-1:0] USAGE_VOLDN   = 8'h80;

  // Saturation limits
  localparam logic [STABLE_W-1:0] STABLE_MAX = 11'd2047;
  localparam logic [UNLOCK_W-1:0] UNLOCK_MAX = 12'd4095;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [1:0] REG_KEEPALIVE = 2'd1;
  localparam logic [1:0] REG_CONN_WAIT = 2'd2;
  localparam logic [1:0] REG_UNLK_GAP  = 2'd3;

  // Register reset values
  localparam logic [DEB_W-1:0]  RST_DEBOUNCE  = 10'd50;
  localparam logic [KEEP_W-1:0] RST_KEEPALIVE = 20'd30000;
  localparam logic [WAIT_W-1:0] RST_CONN_WAIT = 12'd1000;
  localparam logic [GAP_W-1:0]  RST_UNLK_GAP  = 12'd500;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_ms;
    logic [KEEP_W-1:0] keepalive_ms;
    logic [WAIT_W-1:0] connect_wait_ms;
    logic [GAP_W-1:0]  unlock_gap_ms;
  } lkdhid_cfg_t;

  // One queue entry: the reports one tick causes
  typedef struct packed {
    logic               key_valid;
    logic [USAGE_W-1:0] key_usage;
    logic               help_valid;
  } lkdhid_entry_t;

  // Window decode of one sample pair
  function automatic logic [KEY_W-1:0] lkdhid_classify(input logic [LADDER_W-1:0] a,
                                                       input logic [LADDER_W-1:0] b);
    logic [KEY_W-1:0] k;
    if (a >= 12'd4055 && b >= 12'd4055) k = KEY_NONE;
    else if (a <= 12'd245) k = KEY_NEXT;
    else if (a >= 12'd328 && a <= 12'd614) k = KEY_PREV;
    else if (a >= 12'd1106 && a <= 12'd1392) k = KEY_PLUS;
    else if (a >= 12'd2048 && a <= 12'd2334) k = KEY_MINUS;
    else if (a >= 12'd2703 && a <= 12'd2989) k = KEY_MUTE;
    else if (b <= 12'd245) k = KEY_SOURCE;
    else if (b >= 12'd328 && b <= 12'd614) k = KEY_ANSWER;
    else if (b >= 12'd1106 && b <= 12'd1392) k = KEY_HANGUP;
    else if (b >= 12'd2048 && b <= 12'd2334) k = KEY_VOICE;
    else k = KEY_UNKNOWN;
    return k;
  endfunction

  // Report byte of a debounced key; zero for keys without a report
  function automatic logic [USAGE_W-1:0] lkdhid_key_usage(input logic [KEY_W-1:0] k);
    logic [USAGE_W-1:0] u;
    case (k)
      KEY_NEXT:  u = USAGE_NEXT;
      KEY_PREV:  u = USAGE_PREV;
      KEY_PLUS:  u = USAGE_VOLUP;
      KEY_MINUS: u = USAGE_VOLDN;
      KEY_MUTE:  u = USAGE_PLAY;
      default:   u = USAGE_RELEASE;
    endcase
    return u;
  endfunction

endpackage

>>> hdl/lkdhid_regs.sv
// APB configuration registers for the ladder keypad block.
// Depends on lkdhid_pkg.
module lkdhid_regs
  import lkdhid_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output lkdhid_cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms     <= RST_DEBOUNCE;
      cfg.keepalive_ms    <= RST_KEEPALIVE;
      cfg.connect_wait_ms <= RST_CONN_WAIT;
      cfg.unlock_gap_ms   <= RST_UNLK_GAP;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_DEBOUNCE:  cfg.debounce_ms     <= pwdata[DEB_W-1:0];
        REG_KEEPALIVE: cfg.keepalive_ms    <= pwdata[KEEP_W-1:0];
        REG_CONN_WAIT: cfg.connect_wait_ms <= pwdata[WAIT_W-1:0];
        REG_UNLK_GAP:  cfg.unlock_gap_ms   <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[3:2])
      REG_DEBOUNCE:  prdata = APB_DW'(cfg.debounce_ms);
      REG_KEEPALIVE: prdata = APB_DW'(cfg.keepalive_ms);
      REG_CONN_WAIT: prdata = APB_DW'(cfg.connect_wait_ms);
      REG_UNLK_GAP:  prdata = APB_DW'(cfg.unlock_gap_ms);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> hdl/lkdhid_front.sv
// Front end: per-tick classification, debounce, unlock sequencer, keepalive.
// Writes one queue entry per tick that causes reports. Depends on lkdhid_pkg.
module lkdhid_front
  import lkdhid_pkg::*;
#(
  parameter int unsigned AWAKE_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  lkdhid_cfg_t         cfg,
  input  logic                tick,
  input  logic [LADDER_W-1:0] ladder_a,
  input  logic [LADDER_W-1:0] ladder_b,
  input  logic                link_up,
  output logic                push,
  output lkdhid_entry_t       entry
);

  localparam int unsigned CMP_W = (AWAKE_BITS > KEEP_W) ? AWAKE_BITS : KEEP_W;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [KEY_W-1:0]      candidate_key, candidate_key_next;
  logic                  attempt_active, attempt_active_next;
  logic [STABLE_W-1:0]   stable_count, stable_count_next;
  logic [KEY_W-1:0]      prior_outcome, prior_outcome_next;
  logic                  link_was_up, link_was_up_next;
  logic [UNLOCK_W-1:0]   unlock_count, unlock_count_next;
  logic [AWAKE_BITS-1:0] awake_elapsed, awake_elapsed_next, awake_inc;

  logic [KEY_W-1:0]      key_class, outcome;
  logic [STABLE_W-1:0]   stable_inc;
  logic [UNLOCK_W-1:0]   unlock_inc, unlock_limit;
  logic [USAGE_W-1:0]    out_usage;
  logic                  have;
  lkdhid_entry_t         ent;

  assign key_class  = lkdhid_classify(ladder_a, ladder_b);
  assign awake_inc  = (awake_elapsed == '1) ? awake_elapsed : awake_elapsed + 1'b1;
  assign stable_inc = (stable_count == STABLE_MAX) ? stable_count : stable_count + 1'b1;
  assign unlock_inc = (unlock_count == UNLOCK_MAX) ? unlock_count : unlock_count + 1'b1;
  assign unlock_limit = (phase == PH_WAIT) ? cfg.connect_wait_ms : cfg.unlock_gap_ms;
  assign out_usage  = lkdhid_key_usage(outcome);

  // next-state logic for one tick
  always_comb begin
    phase_next          = phase;
    candidate_key_next  = candidate_key;
    attempt_active_next = attempt_active;
    stable_count_next   = stable_count;
    prior_outcome_next  = prior_outcome;
    link_was_up_next    = link_was_up;
    unlock_count_next   = unlock_count;
    awake_elapsed_next  = awake_inc;
    have                = 1'b0;
    outcome             = KEY_NONE;
    ent                 = '0;

    if (!link_up) begin
      // link down: abandon unlock and any attempt
      phase_next          = PH_IDLE;
      unlock_count_next   = '0;
      attempt_active_next = 1'b0;
      stable_count_next   = '0;
      link_was_up_next    = 1'b0;
    end else if (!link_was_up) begin
      // first connected tick starts the unlock sequence
      link_was_up_next  = 1'b1;
      phase_next        = PH_WAIT;
      unlock_count_next = '0;
      if (cfg.connect_wait_ms == '0) begin
        phase_next    = PH_GAP;
        ent.key_valid = 1'b1;
        ent.key_usage = USAGE_MENU;
      end
    end else if (phase == PH_WAIT || phase == PH_GAP) begin
      unlock_count_next = unlock_inc;
      if (unlock_inc >= unlock_limit) begin
        ent.key_valid = 1'b1;
        ent.key_usage = USAGE_MENU;
        if (phase == PH_WAIT) begin
          phase_next        = PH_GAP;
          unlock_count_next = '0;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    end else begin
      // key handling; unused phase code falls here and is cleared
      phase_next = PH_IDLE;
      if (!attempt_active) begin
        if (key_class >= KEY_NEXT && key_class <= KEY_VOICE) begin
          attempt_active_next = 1'b1;
          candidate_key_next  = key_class;
          stable_count_next   = '0;
        end else begin
          have = 1'b1;
        end
      end else if (key_class == candidate_key) begin
        stable_count_next = stable_inc;
        if (stable_inc > STABLE_W'(cfg.debounce_ms)) begin
          have                = 1'b1;
          outcome             = candidate_key;
          attempt_active_next = 1'b0;
        end
      end else begin
        have                = 1'b1;
        attempt_active_next = 1'b0;
      end

      if (have) begin
        if (outcome != prior_outcome && out_usage != USAGE_RELEASE) begin
          ent.key_valid = 1'b1;
          ent.key_usage = out_usage;
        end
        prior_outcome_next = outcome;
      end

      // keepalive Help report
      if (CMP_W'(awake_inc) > CMP_W'(cfg.keepalive_ms)) begin
        ent.help_valid     = 1'b1;
        awake_elapsed_next = '0;
      end
    end
  end

  assign push  = tick & (ent.key_valid | ent.help_valid);
  assign entry = ent;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      candidate_key  <= KEY_NONE;
      attempt_active <= 1'b0;
      stable_count   <= '0;
      prior_outcome  <= KEY_NONE;
      link_was_up    <= 1'b0;
      unlock_count   <= '0;
      awake_elapsed  <= '0;
    end else if (tick) begin
      phase          <= phase_next;
      candidate_key  <= candidate_key_next;
      attempt_active <= attempt_active_next;
      stable_count   <= stable_count_next;
      prior_outcome  <= prior_outcome_next;
      link_was_up    <= link_was_up_next;
      unlock_count   <= unlock_count_next;
      awake_elapsed  <= awake_elapsed_next;
    end
  end

  // a link-down tick always leaves the unlock and debounce idle
  a_link_down_clears: assert property (@(posedge clk) disable iff (rst)
    (tick && !link_up) |=> (phase == PH_IDLE && !attempt_active && !link_was_up))
    else $error("link-down tick did not clear unlock/debounce state");

  // unlock only runs while the link is known up
  a_unlock_needs_link: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> link_was_up)
    else $error("unlock phase active without link");

  // an attempt always holds a real key
  a_candidate_valid: assert property (@(posedge clk) disable iff (rst)
    attempt_active |-> (candidate_key >= KEY_NEXT && candidate_key <= KEY_VOICE))
    else $error("debounce attempt with invalid candidate");

endmodule

>>> hdl/lkdhid_fifo.sv
// Two-entry queue between the front end and the report sequencer.
// Depends on lkdhid_pkg.
module lkdhid_fifo
  import lkdhid_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lkdhid_entry_t push_entry,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output lkdhid_entry_t head
);

  lkdhid_entry_t slots [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;

  assign full      = count[1];
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue write while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue fill level out of range");

endmodule

>>> hdl/lkdhid_back.sv
// Report sequencer: expands a queue entry into report bytes (code, release).
// Registered output stage on the master stream. Depends on lkdhid_pkg.
module lkdhid_back
  import lkdhid_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  lkdhid_entry_t      q_head,
  output logic               q_pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [USAGE_W-1:0] m_axis_tdata,   // [7:0] usage_bits
  output logic               m_axis_tlast    // last_of_run
);

  lkdhid_entry_t      cur;
  logic               cur_valid;
  logic [1:0]         step, last_step;
  logic               load_ok, emit, at_last;
  logic [USAGE_W-1:0] code, byte_out;

  // two bytes per report pair; four when both pairs are present
  assign last_step = (cur.key_valid && cur.help_valid) ? 2'd3 : 2'd1;
  assign at_last   = (step == last_step);
  assign load_ok   = !m_axis_tvalid || m_axis_tready;
  assign emit      = cur_valid && load_ok;
  assign q_pop     = q_not_empty && (!cur_valid || (emit && at_last));
  assign code      = (!step[1] && cur.key_valid) ? cur.key_usage : USAGE_HELP;
  assign byte_out  = step[0] ? USAGE_RELEASE : code;

  // sequencer control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      step          <= 2'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (load_ok) m_axis_tvalid <= emit;
      if (q_pop) begin
        cur_valid <= 1'b1;
        step      <= 2'd0;
      end else if (emit && at_last) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        step <= step + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_head;
    if (emit) begin
      m_axis_tdata <= byte_out;
      m_axis_tlast <= at_last;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (step <= last_step))
    else $error("report step past end of entry");

  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur.key_valid || cur.help_valid))
    else $error("empty entry in report sequencer");

  a_release_follows: assert property (@(posedge clk) disable iff (rst)
    (emit && !step[0] && !at_last) |=> (cur_valid && step[0]))
    else $error("report code not followed by release byte");

endmodule

>>> hdl/ladder_key_debounce_to_hid_report.sv
// Ladder keypad decoder: 1 ms ticks in, consumer report bytes out.
// A tick's entry is written into the queue, loaded into the sequencer and registered out.
// Throughput: one tick per cycle while the two-entry queue has room; the sequencer
// sends one byte per cycle while m_axis_tready is high (four bytes for both reports).
// Reset: synchronous active-high rst clears control state, config takes defaults.
// Depends on lkdhid_pkg, lkdhid_regs, lkdhid_front, lkdhid_fifo, lkdhid_back.
module ladder_key_debounce_to_hid_report
  import lkdhid_pkg::*;
#(
  parameter int unsigned AWAKE_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  // tick stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [2*LADDER_W-1:0] s_axis_tdata,   // [11:0] ladder_a, [23:12] ladder_b
  input  logic                  s_axis_tuser,   // link_up
  // report stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [USAGE_W-1:0]    m_axis_tdata,   // [7:0] usage_bits
  output logic                  m_axis_tlast,   // last_of_run
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  lkdhid_cfg_t   cfg;
  lkdhid_entry_t push_entry, head;
  logic          tick, push, pop, full, not_empty;

  assign s_axis_tready = !full;
  assign tick          = s_axis_tvalid & s_axis_tready;

  lkdhid_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lkdhid_front #(
    .AWAKE_BITS (AWAKE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .tick     (tick),
    .ladder_a (s_axis_tdata[LADDER_W-1:0]),
    .ladder_b (s_axis_tdata[2*LADDER_W-1:LADDER_W]),
    .link_up  (s_axis_tuser),
    .push     (push),
    .entry    (push_entry)
  );

  lkdhid_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (full),
    .not_empty  (not_empty),
    .head       (head)
  );

  lkdhid_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (not_empty),
    .q_head        (head),
    .q_pop         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
